// ----- hw/rtl/lpa_pkg.sv -----
// lpa_pkg: shared types, port widths, opcodes and the control store of the
// label pool allocator. Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package lpa_pkg;

    // port widths fixed by the interface
    localparam int OP_W       = 3;
    localparam int LABEL_W    = 10;
    localparam int SIZE_OUT_W = 18;
    localparam int LIVE_OUT_W = 11;

    // default pool shape
    localparam int LABEL_SLOTS_DEF = 1024;
    localparam int MAX_NODES_DEF   = 65536;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_COUNT = 3'd1,
        OP_ALLOC = 3'd2,
        OP_FREE  = 3'd3,
        OP_QUERY = 3'd4
    } opcode_t;

    // control store addresses
    typedef enum logic [4:0] {
        U_FIN     = 5'd0,
        U_CLR0    = 5'd1,
        U_CLR1    = 5'd2,
        U_CLR2    = 5'd3,
        U_CNT0    = 5'd4,
        U_CNT1    = 5'd5,
        U_AL0     = 5'd6,
        U_AL1     = 5'd7,
        U_AL2     = 5'd8,
        U_AL3     = 5'd9,
        U_AL_FULL = 5'd10,
        U_AL_HIT  = 5'd11,
        U_FR0     = 5'd12,
        U_FR1     = 5'd13,
        U_FR2     = 5'd14,
        U_FR3     = 5'd15,
        U_FR4     = 5'd16,
        U_FR5     = 5'd17,
        U_Q0      = 5'd18,
        U_Q1      = 5'd19
    } upc_t;

    // branch conditions
    typedef enum logic [2:0] {
        C_NONE        = 3'd0,
        C_OUT_OF_POOL = 3'd1,
        C_PTR_END     = 3'd2,
        C_HIT_OR_LAST = 3'd3,
        C_RD_EMPTY    = 3'd4,
        C_NOT_TOP     = 3'd5,
        C_PTR_ZERO    = 3'd6,
        C_LIVE_OR_BOT = 3'd7
    } cond_t;

    // read address select
    typedef enum logic {
        RA_PTR = 1'b0,
        RA_LAB = 1'b1
    } rd_sel_t;

    // write address select
    typedef enum logic [1:0] {
        WA_PTR = 2'd0,
        WA_LAB = 2'd1,
        WA_CHK = 2'd2
    } wa_sel_t;

    // write data select
    typedef enum logic [1:0] {
        WD_ZERO    = 2'd0,
        WD_COUNT   = 2'd1,
        WD_RESERVE = 2'd2
    } wd_sel_t;

    // scan pointer operation
    typedef enum logic [2:0] {
        PTR_HOLD = 3'd0,
        PTR_ZERO = 3'd1,
        PTR_INC  = 3'd2,
        PTR_DEC  = 3'd3,
        PTR_LAB  = 3'd4
    } ptr_op_t;

    // pool register update, also selects the result fields
    typedef enum logic [2:0] {
        REG_NONE  = 3'd0,
        REG_CLEAR = 3'd1,
        REG_COUNT = 3'd2,
        REG_ALLOC = 3'd3,
        REG_FULL  = 3'd4,
        REG_FREE  = 3'd5,
        REG_WALK  = 3'd6,
        REG_QUERY = 3'd7
    } reg_op_t;

    // one control word
    typedef struct packed {
        cond_t   cond;
        upc_t    target;
        logic    loop_step;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        ptr_op_t ptr_op;
        reg_op_t reg_op;
        logic    finish;
    } ucw_t;

    localparam ucw_t UCW_NOP = '{
        cond:      C_NONE,
        target:    U_FIN,
        loop_step: 1'b0,
        rd_en:     1'b0,
        rd_sel:    RA_PTR,
        wr_en:     1'b0,
        wa_sel:    WA_PTR,
        wd_sel:    WD_ZERO,
        ptr_op:    PTR_HOLD,
        reg_op:    REG_NONE,
        finish:    1'b0
    };

    // entry point of each operation
    function automatic upc_t dispatch(input logic [OP_W-1:0] op);
        upc_t a;
        unique case (op)
            OP_CLEAR: a = U_CLR0;
            OP_COUNT: a = U_CNT0;
            OP_ALLOC: a = U_AL0;
            OP_FREE:  a = U_FR0;
            OP_QUERY: a = U_Q0;
            default:  a = U_FIN;
        endcase
        return a;
    endfunction

    // control store; a loop step repeats until its condition, which exits
    // to target without doing the step's work
    function automatic ucw_t ucode(input upc_t a);
        ucw_t w;
        w = UCW_NOP;
        unique case (a)
            U_FIN: begin
                w.finish = 1'b1;
            end
            // clear: sweep every entry to zero
            U_CLR0: begin
                w.ptr_op = PTR_ZERO;
            end
            U_CLR1: begin
                w.loop_step = 1'b1;
                w.cond      = C_PTR_END;
                w.target    = U_CLR2;
                w.wr_en     = 1'b1;
                w.wa_sel    = WA_PTR;
                w.wd_sel    = WD_ZERO;
                w.ptr_op    = PTR_INC;
            end
            U_CLR2: begin
                w.reg_op = REG_CLEAR;
                w.finish = 1'b1;
            end
            // count: read entry, write it back bumped
            U_CNT0: begin
                w.cond   = C_OUT_OF_POOL;
                w.target = U_FIN;
                w.rd_en  = 1'b1;
                w.rd_sel = RA_LAB;
            end
            U_CNT1: begin
                w.wr_en  = 1'b1;
                w.wa_sel = WA_LAB;
                w.wd_sel = WD_COUNT;
                w.reg_op = REG_COUNT;
                w.finish = 1'b1;
            end
            // allocate: pipelined upward scan for the first empty entry
            U_AL0: begin
                w.ptr_op = PTR_ZERO;
            end
            U_AL1: begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_PTR;
                w.ptr_op = PTR_INC;
            end
            U_AL2: begin
                w.loop_step = 1'b1;
                w.cond      = C_HIT_OR_LAST;
                w.target    = U_AL3;
                w.rd_en     = 1'b1;
                w.rd_sel    = RA_PTR;
                w.ptr_op    = PTR_INC;
            end
            U_AL3: begin
                w.cond   = C_RD_EMPTY;
                w.target = U_AL_HIT;
            end
            U_AL_FULL: begin
                w.reg_op = REG_FULL;
                w.finish = 1'b1;
            end
            U_AL_HIT: begin
                w.wr_en  = 1'b1;
                w.wa_sel = WA_CHK;
                w.wd_sel = WD_RESERVE;
                w.reg_op = REG_ALLOC;
                w.finish = 1'b1;
            end
            // free: zero the entry, then walk the top label down if needed
            U_FR0: begin
                w.cond   = C_OUT_OF_POOL;
                w.target = U_FIN;
                w.rd_en  = 1'b1;
                w.rd_sel = RA_LAB;
            end
            U_FR1: begin
                w.cond   = C_NOT_TOP;
                w.target = U_FIN;
                w.wr_en  = 1'b1;
                w.wa_sel = WA_LAB;
                w.wd_sel = WD_ZERO;
                w.ptr_op = PTR_LAB;
                w.reg_op = REG_FREE;
            end
            U_FR2: begin
                w.cond   = C_PTR_ZERO;
                w.target = U_FIN;
                w.ptr_op = PTR_DEC;
            end
            U_FR3: begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_PTR;
                w.ptr_op = PTR_DEC;
            end
            U_FR4: begin
                w.loop_step = 1'b1;
                w.cond      = C_LIVE_OR_BOT;
                w.target    = U_FR5;
                w.rd_en     = 1'b1;
                w.rd_sel    = RA_PTR;
                w.ptr_op    = PTR_DEC;
            end
            U_FR5: begin
                w.reg_op = REG_WALK;
                w.finish = 1'b1;
            end
            // query: read entry and report it
            U_Q0: begin
                w.cond   = C_OUT_OF_POOL;
                w.target = U_FIN;
                w.rd_en  = 1'b1;
                w.rd_sel = RA_LAB;
            end
            U_Q1: begin
                w.reg_op = REG_QUERY;
                w.finish = 1'b1;
            end
            default: begin
                w.finish = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/lpa_ram.sv -----
// lpa_ram: generic single-write, single-read memory with registered read data.
// Self-contained; used by the label pool allocator for its entry table.
`timescale 1ns / 1ps

module lpa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port; read data holds when not read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/label_pool_allocator.sv -----
// label_pool_allocator: per-label size table with reserve marks, live count
// and top label, run by a small microprogram. Uses lpa_pkg and lpa_ram.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready) takes one operation: opcode and label.
// Output channel (out_valid/out_ready) gives one result per operation:
// new_label, community_size, live_labels, top_label, pool_full.
// One operation is worked on at a time; in_ready is high whenever the
// sequencer is idle, also while a finished result still waits in the output
// register. A step of the control store runs each cycle unless a finishing
// step waits for the output register; every entry access goes through the
// single read and single write port of the entry memory. Query and count read
// the entry; free zeroes the entry and, when it held the top label, walks
// the top label down past empty entries; allocate scans upward from label
// zero for the first empty entry and reports a full pool when none is found;
// clear sweeps every entry. After reset the block runs a clearing pass over
// the entry memory, holding in_ready low and producing no result.
// A stalled receiver holds the result; a finishing operation then waits
// until the output register is free.
module label_pool_allocator
    import lpa_pkg::*;
#(
    parameter int LABEL_SLOTS = LABEL_SLOTS_DEF,
    parameter int MAX_NODES   = MAX_NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OP_W-1:0]              opcode,
    input  logic [LABEL_W-1:0]           label,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LABEL_W-1:0]           new_label,
    output logic signed [SIZE_OUT_W-1:0] community_size,
    output logic [LIVE_OUT_W-1:0]        live_labels,
    output logic [LABEL_W-1:0]           top_label,
    output logic                         pool_full
);

    localparam int AW      = $clog2(LABEL_SLOTS);
    localparam int PTR_W   = $clog2(LABEL_SLOTS + 1);
    localparam int SIZE_W  = $clog2(MAX_NODES + 1);
    localparam int ENTRY_W = SIZE_W + 1;

    // sequencer state
    logic                  busy_reg, busy_next;
    logic                  silent_reg, silent_next;
    upc_t                  upc_reg, upc_next;
    logic [LABEL_W-1:0]    lab_reg, lab_next;

    // datapath registers
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]         chk_reg, chk_next;
    logic [PTR_W-1:0]      live_reg, live_next;
    logic [AW-1:0]         top_reg, top_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]           new_label_reg, new_label_next;
    logic signed [SIZE_OUT_W-1:0] size_reg, size_next;
    logic [LIVE_OUT_W-1:0]        live_out_reg, live_out_next;
    logic [LABEL_W-1:0]           top_out_reg, top_out_next;
    logic                         full_reg, full_next;

    // memory port signals
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ENTRY_W-1:0]    rd_data;

    // control and decoded datapath values
    ucw_t                  cw;
    logic                  accept;
    logic                  stall;
    logic                  run;
    logic                  cond_hit;
    logic                  act;
    logic                  in_pool;
    logic [AW-1:0]         lab_addr;
    logic                  rd_res;
    logic [SIZE_W-1:0]     rd_size;
    logic                  rd_empty;
    logic [SIZE_W-1:0]     cnt_size;
    logic [ENTRY_W-1:0]    cnt_entry;

    assign cw       = ucode(upc_reg);
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign stall    = cw.finish && out_valid_reg && !out_ready;
    assign run      = busy_reg && !stall;

    // entry decode
    assign in_pool  = 32'(lab_reg) < LABEL_SLOTS;
    assign lab_addr = AW'(lab_reg);
    assign rd_res   = rd_data[SIZE_W];
    assign rd_size  = rd_data[SIZE_W-1:0];
    assign rd_empty = !rd_res && (rd_size == '0);
    assign cnt_size = (rd_size < SIZE_W'(MAX_NODES)) ? rd_size + SIZE_W'(1) : rd_size;
    assign cnt_entry = rd_res ? {1'b0, SIZE_W'(1)} : {1'b0, cnt_size};

    // branch condition
    always_comb
    begin
        unique case (cw.cond)
            C_NONE:        cond_hit = 1'b0;
            C_OUT_OF_POOL: cond_hit = !in_pool;
            C_PTR_END:     cond_hit = (ptr_reg == PTR_W'(LABEL_SLOTS));
            C_HIT_OR_LAST: cond_hit = rd_empty || (chk_reg == AW'(LABEL_SLOTS - 1));
            C_RD_EMPTY:    cond_hit = rd_empty;
            C_NOT_TOP:     cond_hit = (lab_addr != top_reg);
            C_PTR_ZERO:    cond_hit = (ptr_reg == '0);
            C_LIVE_OR_BOT: cond_hit = !rd_empty || (chk_reg == '0);
            default:       cond_hit = 1'b0;
        endcase
    end

    // a loop step that exits does none of its work
    assign act = run && !(cw.loop_step && cond_hit);

    // memory read port
    assign rd_en   = act && cw.rd_en;
    assign rd_addr = (cw.rd_sel == RA_LAB) ? lab_addr : ptr_reg[AW-1:0];

    // memory write port
    assign wr_en = act && cw.wr_en;
    always_comb
    begin
        unique case (cw.wa_sel)
            WA_PTR:  wr_addr = ptr_reg[AW-1:0];
            WA_LAB:  wr_addr = lab_addr;
            WA_CHK:  wr_addr = chk_reg;
            default: wr_addr = ptr_reg[AW-1:0];
        endcase
        unique case (cw.wd_sel)
            WD_ZERO:    wr_data = '0;
            WD_COUNT:   wr_data = cnt_entry;
            WD_RESERVE: wr_data = {1'b1, SIZE_W'(0)};
            default:    wr_data = '0;
        endcase
    end

    lpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LABEL_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // sequencer: dispatch on transfer, then step, jump or repeat
    always_comb
    begin
        busy_next   = busy_reg;
        silent_next = silent_reg;
        upc_next    = upc_reg;
        lab_next    = lab_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = dispatch(opcode);
            lab_next  = label;
        end
        else if (run)
        begin
            if (cw.finish)
            begin
                busy_next   = 1'b0;
                silent_next = 1'b0;
            end
            else if (cond_hit)
            begin
                upc_next = cw.target;
            end
            else if (!cw.loop_step)
            begin
                upc_next = upc_t'(upc_reg + 5'd1);
            end
        end
    end

    // scan pointer and address of the data in the read register
    always_comb
    begin
        ptr_next = ptr_reg;
        chk_next = chk_reg;
        if (act)
        begin
            unique case (cw.ptr_op)
                PTR_HOLD: ptr_next = ptr_reg;
                PTR_ZERO: ptr_next = '0;
                PTR_INC:  ptr_next = ptr_reg + PTR_W'(1);
                PTR_DEC:  ptr_next = ptr_reg - PTR_W'(1);
                PTR_LAB:  ptr_next = PTR_W'(lab_addr);
                default:  ptr_next = ptr_reg;
            endcase
        end
        if (rd_en)
        begin
            chk_next = rd_addr;
        end
    end

    // live count and top label
    always_comb
    begin
        live_next = live_reg;
        top_next  = top_reg;
        if (act)
        begin
            unique case (cw.reg_op)
                REG_CLEAR:
                begin
                    live_next = '0;
                    top_next  = '0;
                end
                REG_COUNT:
                begin
                    if (rd_empty)
                    begin
                        live_next = live_reg + PTR_W'(1);
                    end
                    if (lab_addr > top_reg)
                    begin
                        top_next = lab_addr;
                    end
                end
                REG_ALLOC:
                begin
                    live_next = live_reg + PTR_W'(1);
                    if (chk_reg > top_reg)
                    begin
                        top_next = chk_reg;
                    end
                end
                REG_FREE:
                begin
                    if (!rd_empty && (live_reg != '0))
                    begin
                        live_next = live_reg - PTR_W'(1);
                    end
                end
                REG_WALK:
                begin
                    top_next = chk_reg;
                end
                default:
                begin
                    live_next = live_reg;
                end
            endcase
        end
    end

    // result register, loaded by the finishing step
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        new_label_next = new_label_reg;
        size_next      = size_reg;
        live_out_next  = live_out_reg;
        top_out_next   = top_out_reg;
        full_next      = full_reg;
        if (act && cw.finish && !silent_reg)
        begin
            out_valid_next = 1'b1;
            new_label_next = (cw.reg_op == REG_ALLOC) ? LABEL_W'(chk_reg) : '0;
            if (cw.reg_op == REG_QUERY)
            begin
                size_next = rd_res ? '1 : SIZE_OUT_W'(rd_size);
            end
            else
            begin
                size_next = '0;
            end
            live_out_next = LIVE_OUT_W'(live_next);
            top_out_next  = LABEL_W'(top_next);
            full_next     = (cw.reg_op == REG_FULL);
        end
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            silent_reg    <= 1'b1;
            upc_reg       <= U_CLR0;
            live_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            silent_reg    <= silent_next;
            upc_reg       <= upc_next;
            live_reg      <= live_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lab_reg       <= lab_next;
        ptr_reg       <= ptr_next;
        chk_reg       <= chk_next;
        new_label_reg <= new_label_next;
        size_reg      <= size_next;
        live_out_reg  <= live_out_next;
        top_out_reg   <= top_out_next;
        full_reg      <= full_next;
    end

    assign out_valid      = out_valid_reg;
    assign new_label      = new_label_reg;
    assign community_size = size_reg;
    assign live_labels    = live_out_reg;
    assign top_label      = top_out_reg;
    assign pool_full      = full_reg;

endmodule

// ----- hw/rtl/lpa_checker.sv -----
// lpa_checker: port-level assertions for the label pool allocator, bound to
// the top level below. Uses lpa_pkg for the port widths.
`timescale 1ns / 1ps

module lpa_checker
    import lpa_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [OP_W-1:0]              opcode,
    input logic [LABEL_W-1:0]           label,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [LABEL_W-1:0]           new_label,
    input logic signed [SIZE_OUT_W-1:0] community_size,
    input logic [LIVE_OUT_W-1:0]        live_labels,
    input logic [LABEL_W-1:0]           top_label,
    input logic                         pool_full
);

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(label))
        else $error("input payload changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_label)
            && $stable(community_size) && $stable(live_labels)
            && $stable(top_label) && $stable(pool_full))
        else $error("result changed while stalled");

    // an input transfer always leaves the sequencer busy, in_ready low, in the cycle after it
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a transfer");

    // a full pool hands out nothing and reports no size
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pool_full |-> new_label == '0 && community_size == '0)
        else $error("full result carries a label or size");

    // a reported size comes only from a query, never with an allocation
    a_size_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && community_size != '0 |-> new_label == '0 && !pool_full)
        else $error("size reported together with allocate fields");

endmodule

bind label_pool_allocator lpa_checker u_lpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .label          (label),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_label      (new_label),
    .community_size (community_size),
    .live_labels    (live_labels),
    .top_label      (top_label),
    .pool_full      (pool_full)
);

// ----- test/tb_label_pool_allocator.sv -----
// tb_label_pool_allocator: self-checking bench for the label pool allocator.
// Drives opcode/label transfers, predicts each result from its own pool copy
// and checks every result field; depends on lpa_pkg and label_pool_allocator.
`timescale 1ns / 1ps

module tb_label_pool_allocator;
    import lpa_pkg::*;

    // opcodes with no operation behind them
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int IDLE_PCT      = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_OPS    = 560;
    localparam int REPORT_CAP    = 40;
    localparam int TOP_SLOT      = LABEL_SLOTS_DEF - 1;

    // one pending operation; drain makes the sender wait for every result first
    typedef struct packed {
        logic               drain;
        logic [OP_W-1:0]    op;
        logic [LABEL_W-1:0] lab;
    } pool_op_t;

    // one result of the block
    typedef struct packed {
        logic [LABEL_W-1:0]    new_label;
        logic [SIZE_OUT_W-1:0] size;
        logic [LIVE_OUT_W-1:0] live;
        logic [LABEL_W-1:0]    top;
        logic                  full;
    } pool_result_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [OP_W-1:0]              opcode    = '0;
    logic [LABEL_W-1:0]           label     = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [LABEL_W-1:0]           new_label;
    logic signed [SIZE_OUT_W-1:0] community_size;
    logic [LIVE_OUT_W-1:0]        live_labels;
    logic [LABEL_W-1:0]           top_label;
    logic                         pool_full;

    // predicted pool contents
    logic [16:0]     slot_size [LABEL_SLOTS_DEF];
    logic            slot_resv [LABEL_SLOTS_DEF];
    int unsigned     pool_live;
    int unsigned     pool_top;

    pool_op_t        op_backlog [$];
    pool_result_t    pool_answers [$];

    int              ops_taken    = 0;
    int              answers_seen = 0;
    int              op_hits [8];
    int              full_seen    = 0;
    int              fail_count   = 0;
    int              hold_at      = -1;
    int              hold_left    = 0;
    logic            hold_armed   = 1'b1;
    int              calm_lo      = -1;
    int              calm_hi      = -1;
    longint          cycle_budget = 0;
    longint          cycle_limit  = 64'd1 << 40;
    longint          cycle_count  = 0;

    wire calm = (ops_taken >= calm_lo) && (ops_taken < calm_hi);

    label_pool_allocator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .label          (label),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_label      (new_label),
        .community_size (community_size),
        .live_labels    (live_labels),
        .top_label      (top_label),
        .pool_full      (pool_full)
    );

    always #6 clk = ~clk;

    // an entry is free when it holds no nodes and no reservation
    function automatic logic slot_free(input int unsigned idx);
        return slot_size[idx] == 0 && !slot_resv[idx];
    endfunction

    // apply one operation to the predicted pool and form its result
    function automatic void pool_apply(input logic [OP_W-1:0] op,
                                       input logic [LABEL_W-1:0] lab,
                                       output pool_result_t r);
        int unsigned i;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                for (i = 0; i < LABEL_SLOTS_DEF; i++)
                begin
                    slot_size[i] = '0;
                    slot_resv[i] = 1'b0;
                end
                pool_live = 0;
                pool_top  = 0;
            end
            OP_COUNT:
            begin
                // counting onto a reservation replaces it with a single node
                if (slot_resv[lab])
                begin
                    slot_resv[lab] = 1'b0;
                    slot_size[lab] = 17'd1;
                end
                else
                begin
                    if (slot_size[lab] == 0)
                        pool_live++;
                    if (slot_size[lab] < MAX_NODES_DEF)
                        slot_size[lab]++;
                end
                if (lab > pool_top)
                    pool_top = lab;
            end
            OP_ALLOC:
            begin
                i = 0;
                while (i < LABEL_SLOTS_DEF && !slot_free(i))
                    i++;
                if (i >= LABEL_SLOTS_DEF)
                    r.full = 1'b1;
                else
                begin
                    slot_resv[i] = 1'b1;
                    pool_live++;
                    if (i > pool_top)
                        pool_top = i;
                    r.new_label = LABEL_W'(i);
                end
            end
            OP_FREE:
            begin
                if (!slot_free(lab) && pool_live > 0)
                    pool_live--;
                slot_size[lab] = '0;
                slot_resv[lab] = 1'b0;
                // walk the top label down past empty entries
                if (lab == pool_top)
                    while (pool_top > 0 && slot_free(pool_top))
                        pool_top--;
            end
            OP_QUERY:
            begin
                if (slot_resv[lab])
                    r.size = '1;
                else
                    r.size = SIZE_OUT_W'(slot_size[lab]);
            end
            default:
            begin
            end
        endcase
        r.live = LIVE_OUT_W'(pool_live);
        r.top  = LABEL_W'(pool_top);
    endfunction

    // queue one operation and add its worst case to the cycle budget
    task automatic push_op(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] lab,
                           input logic drain);
        op_backlog.push_back('{drain: drain, op: op, lab: lab});
        cycle_budget += 48;
        if (op == OP_CLEAR || op == OP_ALLOC || op == OP_FREE)
            cycle_budget += LABEL_SLOTS_DEF + 8;
    endtask

    function automatic void report(input string what, input logic signed [31:0] want,
                                   input logic signed [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        else if (fail_count == REPORT_CAP + 1)
            $display("%0t: further mismatches are counted but not listed", $time);
    endfunction

    // sender: offers queued operations and predicts each one on its transfer
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t ans;
        logic         took;
        logic         offer_next;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= '0;
            label     <= '0;
            ops_taken <= 0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                pool_apply(opcode, label, ans);
                pool_answers.push_back(ans);
                op_hits[opcode] += 1;
                ops_taken <= ops_taken + 1;
            end
            if (!in_valid || took)
            begin
                offer_next = op_backlog.size() != 0 &&
                             (calm || $urandom_range(99) >= IDLE_PCT);
                if (offer_next && op_backlog[0].drain)
                    offer_next = !took && ops_taken == answers_seen;
                if (offer_next)
                begin
                    in_valid <= 1'b1;
                    opcode   <= op_backlog[0].op;
                    label    <= op_backlog[0].lab;
                    void'(op_backlog.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver hold-off: one long stretch with out_ready low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && ops_taken == hold_at)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // receiver: checks every result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t got;
        pool_result_t want;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            answers_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{new_label, community_size, live_labels, top_label, pool_full};
                if (got.full === 1'b1)
                    full_seen++;
                if (pool_answers.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, got label %0d size %0d",
                             $time, got.new_label, $signed(got.size));
                end
                else
                begin
                    want = pool_answers.pop_front();
                    if (got.new_label !== want.new_label)
                        report("new_label", 32'(want.new_label), 32'(got.new_label));
                    if (got.size !== want.size)
                        report("community_size", 32'($signed(want.size)),
                               32'($signed(got.size)));
                    if (got.live !== want.live)
                        report("live_labels", 32'(want.live), 32'(got.live));
                    if (got.top !== want.top)
                        report("top_label", 32'(want.top), 32'(got.top));
                    if (got.full !== want.full)
                        report("pool_full", 32'(want.full), 32'(got.full));
                end
                answers_seen <= answers_seen + 1;
            end
            out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("%0t: no progress after %0d cycles", $time, cycle_count);
            $display("** label_pool_allocator: FAILED **");
            $finish;
        end
    end

    // stimulus, then wait for the last result and judge the run
    initial
    begin
        int                 n;
        int                 pick;
        int                 ops_base;
        logic [OP_W-1:0]    op;
        logic [LABEL_W-1:0] lab;

        for (n = 0; n < LABEL_SLOTS_DEF; n++)
        begin
            slot_size[n] = '0;
            slot_resv[n] = 1'b0;
        end
        pool_live = 0;
        pool_top  = 0;
        for (n = 0; n < 8; n++)
            op_hits[n] = 0;

        // directed: reservations, top walk, idle frees, spare opcodes, clear
        push_op(OP_QUERY, 10'd0, 1'b0);
        push_op(OP_ALLOC, 10'd0, 1'b0);
        push_op(OP_QUERY, 10'd0, 1'b0);
        push_op(OP_COUNT, 10'd0, 1'b0);
        push_op(OP_COUNT, LABEL_W'(TOP_SLOT), 1'b0);
        push_op(OP_QUERY, LABEL_W'(TOP_SLOT), 1'b0);
        push_op(OP_FREE, 10'd512, 1'b0);
        push_op(OP_ALLOC, 10'h3FF, 1'b0);
        push_op(OP_FREE, LABEL_W'(TOP_SLOT), 1'b0);
        push_op(OP_FREE, 10'd0, 1'b0);
        push_op(OP_FREE, 10'd1, 1'b0);
        push_op(OP_FREE, 10'd0, 1'b0);
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++)
            push_op(op, 10'h2AA, 1'b0);
        push_op(OP_COUNT, 10'h155, 1'b0);
        push_op(OP_COUNT, 10'h2AA, 1'b0);
        push_op(OP_ALLOC, 10'd0, 1'b0);
        push_op(OP_FREE, 10'h2AA, 1'b0);
        push_op(OP_QUERY, 10'h155, 1'b0);
        push_op(OP_CLEAR, 10'h3FF, 1'b0);
        push_op(OP_ALLOC, 10'd0, 1'b0);

        // random mix, labels mostly in a small window so frees and queries hit
        ops_base = op_backlog.size();
        hold_at  = ops_base + 60;
        calm_lo  = ops_base + 200;
        calm_hi  = ops_base + 360;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0)
                lab = LABEL_W'($urandom);
            else
                lab = LABEL_W'($urandom_range(31));
            if (pick < 3)
                op = OP_CLEAR;
            else if (pick < 38)
                op = OP_COUNT;
            else if (pick < 53)
                op = OP_ALLOC;
            else if (pick < 73)
                op = OP_FREE;
            else if (pick < 96)
                op = OP_QUERY;
            else
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            push_op(op, lab, n == 0 || n == RANDOM_OPS / 2);
        end

        cycle_limit = 4 * (cycle_budget + LABEL_SLOTS_DEF + HOLD_CYCLES) + 10000;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge, where every transfer has settled
        while (!(op_backlog.size() == 0 && !in_valid && ops_taken == answers_seen))
            @(negedge clk);
        repeat (LABEL_SLOTS_DEF + 16) @(negedge clk);

        if (pool_answers.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, pool_answers.size());
        end

        $display("run: %0d operations, %0d results; clear %0d, count %0d, allocate %0d",
                 ops_taken, answers_seen, op_hits[OP_CLEAR], op_hits[OP_COUNT],
                 op_hits[OP_ALLOC]);
        $display("run: free %0d, query %0d, spare opcodes %0d, full pool seen %0d times",
                 op_hits[OP_FREE], op_hits[OP_QUERY],
                 op_hits[5] + op_hits[6] + op_hits[7], full_seen);
        if (fail_count == 0)
            $display("** label_pool_allocator: PASSED **");
        else
            $display("** label_pool_allocator: FAILED **");
        $finish;
    end

endmodule
